/* sv/mie_pkg.sv */
// Package with shared types and constants of the MIPS32 integer execute block.
`timescale 1ns / 1ps
package mie_pkg;

    localparam logic [5:0] OP_SPECIAL = 6'h00;
    localparam logic [5:0] OP_REGIMM  = 6'h01;
    localparam logic [5:0] OP_J       = 6'h02;
    localparam logic [5:0] OP_JAL     = 6'h03;
    localparam logic [5:0] OP_BEQ     = 6'h04;
    localparam logic [5:0] OP_BNE     = 6'h05;
    localparam logic [5:0] OP_BLEZ    = 6'h06;
    localparam logic [5:0] OP_BGTZ    = 6'h07;
    localparam logic [5:0] OP_ADDI    = 6'h08;
    localparam logic [5:0] OP_ADDIU   = 6'h09;
    localparam logic [5:0] OP_SLTI    = 6'h0a;
    localparam logic [5:0] OP_SLTIU   = 6'h0b;
    localparam logic [5:0] OP_ANDI    = 6'h0c;
    localparam logic [5:0] OP_ORI     = 6'h0d;
    localparam logic [5:0] OP_XORI    = 6'h0e;
    localparam logic [5:0] OP_LUI     = 6'h0f;

    localparam logic [5:0] FN_SLL   = 6'h00;
    localparam logic [5:0] FN_SRL   = 6'h02;
    localparam logic [5:0] FN_SRA   = 6'h03;
    localparam logic [5:0] FN_SLLV  = 6'h04;
    localparam logic [5:0] FN_SRLV  = 6'h06;
    localparam logic [5:0] FN_SRAV  = 6'h07;
    localparam logic [5:0] FN_JR    = 6'h08;
    localparam logic [5:0] FN_JALR  = 6'h09;
    localparam logic [5:0] FN_MFHI  = 6'h10;
    localparam logic [5:0] FN_MTHI  = 6'h11;
    localparam logic [5:0] FN_MFLO  = 6'h12;
    localparam logic [5:0] FN_MTLO  = 6'h13;
    localparam logic [5:0] FN_MULT  = 6'h18;
    localparam logic [5:0] FN_MULTU = 6'h19;
    localparam logic [5:0] FN_DIV   = 6'h1a;
    localparam logic [5:0] FN_DIVU  = 6'h1b;
    localparam logic [5:0] FN_ADD   = 6'h20;
    localparam logic [5:0] FN_ADDU  = 6'h21;
    localparam logic [5:0] FN_SUB   = 6'h22;
    localparam logic [5:0] FN_SUBU  = 6'h23;
    localparam logic [5:0] FN_AND   = 6'h24;
    localparam logic [5:0] FN_OR    = 6'h25;
    localparam logic [5:0] FN_XOR   = 6'h26;
    localparam logic [5:0] FN_NOR   = 6'h27;
    localparam logic [5:0] FN_SLT   = 6'h2a;
    localparam logic [5:0] FN_SLTU  = 6'h2b;

    localparam logic [4:0] RI_BLTZ   = 5'h00;
    localparam logic [4:0] RI_BGEZ   = 5'h01;
    localparam logic [4:0] RI_BLTZAL = 5'h10;
    localparam logic [4:0] RI_BGEZAL = 5'h11;

    localparam logic [4:0] LINK_REG = 5'd31;
    localparam logic [31:0] PC_RESET = 32'hBFC0_0000;
    localparam int DIV_STEPS = 32;

    // Kind of multi-cycle work the datapath runs for one item.
    typedef enum logic [1:0] {
        XK_NONE,
        XK_MUL,
        XK_DIV
    } xkind_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic decode;
        logic mul_hi;
        logic div_step;
        logic finish;
        logic out_load;
        logic restart;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        xkind_t kind;
        logic   div_last;
    } stat_t;

    // One result item.
    typedef struct packed {
        logic [31:0] instr_pc;
        logic [4:0]  dest_index;
        logic [31:0] dest_value;
        logic        dest_write;
        logic        hilo_write;
        logic        branch_taken;
        logic [31:0] next_pc;
        logic        illegal_op;
        logic        div_zero;
    } result_t;

endpackage

/* sv/mie_in_if.sv */
// Channel interface that carries one instruction item.
`timescale 1ns / 1ps
interface mie_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] instr_word;

    modport source (output valid, output instr_word, input ready);
    modport sink (input valid, input instr_word, output ready);
endinterface

/* sv/mie_out_if.sv */
// Channel interface that carries one result item.
`timescale 1ns / 1ps
interface mie_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] instr_pc;
    logic [4:0]  dest_index;
    logic [31:0] dest_value;
    logic        dest_write;
    logic        hilo_write;
    logic        branch_taken;
    logic [31:0] next_pc;
    logic        illegal_op;
    logic        div_zero;

    modport source (output valid, output instr_pc, output dest_index, output dest_value,
                    output dest_write, output hilo_write, output branch_taken,
                    output next_pc, output illegal_op, output div_zero, input ready);
    modport sink (input valid, input instr_pc, input dest_index, input dest_value,
                  input dest_write, input hilo_write, input branch_taken,
                  input next_pc, input illegal_op, input div_zero, output ready);
endinterface

/* sv/mie_ctrl.sv */
// Controller state machine that sequences decode, multiply, divide and result hand-off.
`timescale 1ns / 1ps
module mie_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  logic              cfg_we,
    input  mie_pkg::stat_t    stat,
    output mie_pkg::cmd_t     cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_MUL,
        S_DIV,
        S_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   busy;

    assign busy = (state_reg != S_IDLE) || (out_valid_reg && !out_ready);
    assign in_ready  = !busy;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        cmd.restart    = cfg_we;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    cmd.decode = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (stat.kind)
                    mie_pkg::XK_MUL: state_next = S_MUL;
                    mie_pkg::XK_DIV: state_next = S_DIV;
                    default:         state_next = S_FINISH;
                endcase
            end
            S_MUL:
            begin
                cmd.mul_hi = 1'b1;
                state_next = S_FINISH;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.finish     = 1'b1;
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

/* sv/mie_dp.sv */
// Datapath with register file, HI/LO, pc, branch-delay state, multiplier and divider.
`timescale 1ns / 1ps
module mie_dp (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [31:0]       instr_word,
    input  logic [31:0]       cfg_data,
    input  mie_pkg::cmd_t     cmd,
    output mie_pkg::stat_t    stat,
    output mie_pkg::result_t  result
);

    logic [31:0] gpr_mem [32];
    logic [31:0] gvld_reg;
    logic [31:0] a_reg, b_reg, w_reg;
    logic [31:0] hi_reg, lo_reg, pc_reg, tgt_reg;
    logic        pend_reg;
    logic [31:0] hi_next, lo_next;
    mie_pkg::xkind_t kind;

    logic [5:0]  op, fn;
    logic [4:0]  rs, rt, rd, sh, sa;
    logic [15:0] imm;
    logic [31:0] simm, seq, btgt, jtgt, link;

    // Multiplier works on 33-bit operands split into low and high halves of the product.
    logic [32:0] ma, mb;
    logic [65:0] prod_full;
    logic [31:0] plo_reg;

    // Divider state: restoring, one quotient bit per cycle.
    logic [31:0] quo_reg, rem_reg, dvs_reg;
    logic [5:0]  dcnt_reg;
    logic        dneg_q_reg, dneg_r_reg, dzero_reg;
    logic [32:0] rem_shift;
    logic [32:0] rem_sub;

    logic [31:0] dval;
    logic [4:0]  dreg;
    logic        dw, hw, taken, ill, dz;
    logic [31:0] target;

    assign op  = w_reg[31:26];
    assign rs  = w_reg[25:21];
    assign rt  = w_reg[20:16];
    assign rd  = w_reg[15:11];
    assign sh  = w_reg[10:6];
    assign fn  = w_reg[5:0];
    assign imm = w_reg[15:0];
    assign sa  = a_reg[4:0];
    assign simm = {{16{imm[15]}}, imm};
    assign seq  = pc_reg + 32'd4;
    assign link = pc_reg + 32'd8;
    assign btgt = seq + {simm[29:0], 2'b00};
    assign jtgt = {seq[31:28], w_reg[25:0], 2'b00};

    assign ma = {(fn == mie_pkg::FN_MULT) && a_reg[31], a_reg};
    assign mb = {(fn == mie_pkg::FN_MULT) && b_reg[31], b_reg};
    assign prod_full = $signed(ma) * $signed(mb);

    assign rem_shift = {rem_reg, quo_reg[31]};
    assign rem_sub   = rem_shift - {1'b0, dvs_reg};

    always_comb
    begin
        kind = mie_pkg::XK_NONE;
        if (op == mie_pkg::OP_SPECIAL)
        begin
            case (fn)
                mie_pkg::FN_MULT, mie_pkg::FN_MULTU: kind = mie_pkg::XK_MUL;
                mie_pkg::FN_DIV, mie_pkg::FN_DIVU:   kind = mie_pkg::XK_DIV;
                default:                             kind = mie_pkg::XK_NONE;
            endcase
        end
    end

    assign stat.kind     = kind;
    assign stat.div_last = (dcnt_reg == 6'(mie_pkg::DIV_STEPS - 1)) || dzero_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.decode)
        begin
            w_reg <= instr_word;
            a_reg <= gvld_reg[instr_word[25:21]] ? gpr_mem[instr_word[25:21]] : 32'd0;
            b_reg <= gvld_reg[instr_word[20:16]] ? gpr_mem[instr_word[20:16]] : 32'd0;
        end
        if (cmd.finish && dw && dreg != 5'd0)
        begin
            gpr_mem[dreg] <= dval;
        end
    end

    // A register reads as zero until it is first written.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gvld_reg <= '0;
        end
        else if (cmd.finish && dw)
        begin
            gvld_reg[dreg] <= 1'b1;
        end
    end

    // Divider preload happens in every cycle without a divide step; the product low
    // half is captured in the multiply cycle.
    always_ff @(posedge clk)
    begin
        if (cmd.mul_hi)
        begin
            plo_reg <= prod_full[31:0];
        end
        if (cmd.div_step)
        begin
            if (!rem_sub[32])
            begin
                rem_reg <= rem_sub[31:0];
                quo_reg <= {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_shift[31:0];
                quo_reg <= {quo_reg[30:0], 1'b0};
            end
            dcnt_reg <= dcnt_reg + 6'd1;
        end
        else
        begin
            dcnt_reg   <= '0;
            rem_reg    <= '0;
            dzero_reg  <= (b_reg == 32'd0);
            dneg_q_reg <= (fn == mie_pkg::FN_DIV) && (a_reg[31] != b_reg[31]);
            dneg_r_reg <= (fn == mie_pkg::FN_DIV) && a_reg[31];
            quo_reg    <= ((fn == mie_pkg::FN_DIV) && a_reg[31]) ? 32'd0 - a_reg : a_reg;
            dvs_reg    <= ((fn == mie_pkg::FN_DIV) && b_reg[31]) ? 32'd0 - b_reg : b_reg;
        end
    end

    always_comb
    begin
        dval    = '0;
        dreg    = '0;
        dw      = 1'b0;
        hw      = 1'b0;
        taken   = 1'b0;
        ill     = 1'b0;
        dz      = 1'b0;
        target  = '0;
        hi_next = hi_reg;
        lo_next = lo_reg;
        if (op == mie_pkg::OP_SPECIAL)
        begin
            dreg = rd;
            dw   = 1'b1;
            case (fn)
                mie_pkg::FN_SLL:  dval = b_reg << sh;
                mie_pkg::FN_SRL:  dval = b_reg >> sh;
                mie_pkg::FN_SRA:  dval = 32'($signed(b_reg) >>> sh);
                mie_pkg::FN_SLLV: dval = b_reg << sa;
                mie_pkg::FN_SRLV: dval = b_reg >> sa;
                mie_pkg::FN_SRAV: dval = 32'($signed(b_reg) >>> sa);
                mie_pkg::FN_JR:
                begin
                    dw = 1'b0;
                    taken = 1'b1;
                    target = a_reg;
                end
                mie_pkg::FN_JALR:
                begin
                    dreg = mie_pkg::LINK_REG;
                    dval = link;
                    taken = 1'b1;
                    target = a_reg;
                end
                mie_pkg::FN_MFHI: dval = hi_reg;
                mie_pkg::FN_MFLO: dval = lo_reg;
                mie_pkg::FN_MTHI:
                begin
                    dw = 1'b0;
                    hw = 1'b1;
                    hi_next = a_reg;
                end
                mie_pkg::FN_MTLO:
                begin
                    dw = 1'b0;
                    hw = 1'b1;
                    lo_next = a_reg;
                end
                mie_pkg::FN_MULT, mie_pkg::FN_MULTU:
                begin
                    dw = 1'b0;
                    hw = 1'b1;
                    lo_next = plo_reg;
                    hi_next = prod_full[63:32];
                end
                mie_pkg::FN_DIV, mie_pkg::FN_DIVU:
                begin
                    dw = 1'b0;
                    if (dzero_reg)
                    begin
                        dz = 1'b1;
                    end
                    else
                    begin
                        hw = 1'b1;
                        lo_next = dneg_q_reg ? 32'd0 - quo_reg : quo_reg;
                        hi_next = dneg_r_reg ? 32'd0 - rem_reg : rem_reg;
                    end
                end
                mie_pkg::FN_ADD, mie_pkg::FN_ADDU: dval = a_reg + b_reg;
                mie_pkg::FN_SUB, mie_pkg::FN_SUBU: dval = a_reg - b_reg;
                mie_pkg::FN_AND:  dval = a_reg & b_reg;
                mie_pkg::FN_OR:   dval = a_reg | b_reg;
                mie_pkg::FN_XOR:  dval = a_reg ^ b_reg;
                mie_pkg::FN_NOR:  dval = ~(a_reg | b_reg);
                mie_pkg::FN_SLT:  dval = {31'd0, $signed(a_reg) < $signed(b_reg)};
                mie_pkg::FN_SLTU: dval = {31'd0, a_reg < b_reg};
                default:
                begin
                    dw = 1'b0;
                    ill = 1'b1;
                end
            endcase
        end
        else if (op == mie_pkg::OP_REGIMM)
        begin
            target = btgt;
            case (rt)
                mie_pkg::RI_BLTZ: taken = a_reg[31];
                mie_pkg::RI_BGEZ: taken = !a_reg[31];
                mie_pkg::RI_BLTZAL, mie_pkg::RI_BGEZAL:
                begin
                    taken = a_reg[31] ^ rt[0];
                    dw = 1'b1;
                    dreg = mie_pkg::LINK_REG;
                    dval = link;
                end
                default: ill = 1'b1;
            endcase
        end
        else
        begin
            dreg = rt;
            case (op)
                mie_pkg::OP_J:
                begin
                    taken = 1'b1;
                    target = jtgt;
                end
                mie_pkg::OP_JAL:
                begin
                    taken = 1'b1;
                    target = jtgt;
                    dw = 1'b1;
                    dreg = mie_pkg::LINK_REG;
                    dval = link;
                end
                mie_pkg::OP_BEQ:
                begin
                    taken = (a_reg == b_reg);
                    target = btgt;
                end
                mie_pkg::OP_BNE:
                begin
                    taken = (a_reg != b_reg);
                    target = btgt;
                end
                mie_pkg::OP_BLEZ:
                begin
                    taken = (a_reg == 32'd0) || a_reg[31];
                    target = btgt;
                end
                mie_pkg::OP_BGTZ:
                begin
                    taken = (a_reg != 32'd0) && !a_reg[31];
                    target = btgt;
                end
                mie_pkg::OP_ADDI, mie_pkg::OP_ADDIU:
                begin
                    dw = 1'b1;
                    dval = a_reg + simm;
                end
                mie_pkg::OP_SLTI:
                begin
                    dw = 1'b1;
                    dval = {31'd0, $signed(a_reg) < $signed(simm)};
                end
                mie_pkg::OP_SLTIU:
                begin
                    dw = 1'b1;
                    dval = {31'd0, a_reg < simm};
                end
                mie_pkg::OP_ANDI:
                begin
                    dw = 1'b1;
                    dval = a_reg & {16'd0, imm};
                end
                mie_pkg::OP_ORI:
                begin
                    dw = 1'b1;
                    dval = a_reg | {16'd0, imm};
                end
                mie_pkg::OP_XORI:
                begin
                    dw = 1'b1;
                    dval = a_reg ^ {16'd0, imm};
                end
                mie_pkg::OP_LUI:
                begin
                    dw = 1'b1;
                    dval = {imm, 16'd0};
                end
                default: ill = 1'b1;
            endcase
        end
        if (!dw || dreg == 5'd0)
        begin
            dw = 1'b0;
            dreg = '0;
            dval = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hi_reg   <= '0;
            lo_reg   <= '0;
            pc_reg   <= mie_pkg::PC_RESET;
            pend_reg <= 1'b0;
            tgt_reg  <= '0;
        end
        else if (cmd.restart)
        begin
            pc_reg   <= cfg_data;
            pend_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            hi_reg   <= hi_next;
            lo_reg   <= lo_next;
            pc_reg   <= pend_reg ? tgt_reg : seq;
            pend_reg <= taken;
            if (taken)
            begin
                tgt_reg <= target;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            result.instr_pc     <= pc_reg;
            result.dest_index   <= dreg;
            result.dest_value   <= dval;
            result.dest_write   <= dw;
            result.hilo_write   <= hw;
            result.branch_taken <= taken;
            result.next_pc      <= pend_reg ? tgt_reg : seq;
            result.illegal_op   <= ill;
            result.div_zero     <= dz;
        end
    end

endmodule

/* sv/mips32_integer_execute.sv */
// Top level of the MIPS32 integer execute block.
`timescale 1ns / 1ps
// Executes one MIPS32 integer instruction per input item and returns one result item
// for it. Most instructions go from acceptance through register read, execute and the
// result register; mult and multu pass an extra multiply state, in which the low product
// half is registered, and div and divu step the restoring divider, which produces one
// quotient bit a cycle, up to the last bit (a zero divisor ends the division early).
// A result that waits on the output adds its wait to the next item. One item is in work
// at a time. Writing reset_pc restarts the pc and drops a pending branch target; do so
// only while idle.
module mips32_integer_execute (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [31:0] cfg_data,
    mie_in_if.sink      in_ch,
    mie_out_if.source   out_ch
);

    mie_pkg::cmd_t    cmd;
    mie_pkg::stat_t   stat;
    mie_pkg::result_t result;
    logic             out_valid;

    mie_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_valid),
        .out_ready (out_ch.ready),
        .cfg_we    (cfg_we),
        .stat      (stat),
        .cmd       (cmd)
    );

    mie_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .instr_word (in_ch.instr_word),
        .cfg_data   (cfg_data),
        .cmd        (cmd),
        .stat       (stat),
        .result     (result)
    );

    assign out_ch.valid        = out_valid;
    assign out_ch.instr_pc     = result.instr_pc;
    assign out_ch.dest_index   = result.dest_index;
    assign out_ch.dest_value   = result.dest_value;
    assign out_ch.dest_write   = result.dest_write;
    assign out_ch.hilo_write   = result.hilo_write;
    assign out_ch.branch_taken = result.branch_taken;
    assign out_ch.next_pc      = result.next_pc;
    assign out_ch.illegal_op   = result.illegal_op;
    assign out_ch.div_zero     = result.div_zero;

`ifndef NO_ASSERTIONS
    a_no_accept_while_full: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.ready) |-> !in_ch.ready)
        else $error("Item accepted while a result was still waiting.");

    a_result_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
        else $error("Second item accepted while one was in work.");

    a_zero_reg_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.dest_write) |->
        (out_ch.dest_index == 5'd0 && out_ch.dest_value == 32'd0))
        else $error("Register fields set without a register write.");
`endif

endmodule

/* sim/tb.sv */
// Self-checking testbench for the MIPS32 integer execute block with random instruction streams.
`timescale 1ns / 1ps
module tb;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [31:0] cfg_data;

    mie_in_if  in_ch ();
    mie_out_if out_ch ();

    mips32_integer_execute dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg_we (cfg_we),
        .cfg_data (cfg_data),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    logic [31:0] gpr [32];
    logic [31:0] hi_val;
    logic [31:0] lo_val;
    logic [31:0] pc_val;
    logic        slot_pending;
    logic [31:0] slot_target;

    logic [31:0]      instr_queue [$];
    mie_pkg::result_t result_queue [$];
    int          error_count;
    int          result_count;
    int          accept_count;
    int          pop_count;
    int          cycle_count;
    logic        hold_sender;
    int          send_gap;
    int          recv_gap;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [31:0] sx16(logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        error_count++;
        $display("mismatch %0s at result %0d: got %h want %h", what, result_count, got, want);
    endtask

    task automatic restart_pc(logic [31:0] value);
        pc_val = value;
        slot_pending = 1'b0;
    endtask

    task automatic execute_instr(logic [31:0] w);
        mie_pkg::result_t r;
        logic [5:0]  op;
        logic [5:0]  fn;
        logic [4:0]  rs;
        logic [4:0]  rt;
        logic [4:0]  rd;
        logic [4:0]  sh;
        logic [15:0] imm;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] seq;
        logic [31:0] btgt;
        logic [31:0] jtgt;
        logic [31:0] target;
        logic [31:0] dval;
        logic [4:0]  dreg;
        logic [63:0] prod;
        logic        dw;
        logic        taken;
        op = w[31:26];
        rs = w[25:21];
        rt = w[20:16];
        rd = w[15:11];
        sh = w[10:6];
        fn = w[5:0];
        imm = w[15:0];
        a = gpr[rs];
        b = gpr[rt];
        seq = pc_val + 32'd4;
        btgt = seq + (sx16(imm) << 2);
        jtgt = {seq[31:28], w[25:0], 2'b00};
        r = '0;
        target = '0;
        dval = '0;
        dreg = '0;
        dw = 1'b0;
        taken = 1'b0;
        if (op == mie_pkg::OP_SPECIAL)
        begin
            dreg = rd;
            dw = 1'b1;
            case (fn)
                mie_pkg::FN_SLL: dval = b << sh;
                mie_pkg::FN_SRL: dval = b >> sh;
                mie_pkg::FN_SRA: dval = $signed(b) >>> sh;
                mie_pkg::FN_SLLV: dval = b << a[4:0];
                mie_pkg::FN_SRLV: dval = b >> a[4:0];
                mie_pkg::FN_SRAV: dval = $signed(b) >>> a[4:0];
                mie_pkg::FN_JR:
                begin
                    dw = 1'b0;
                    taken = 1'b1;
                    target = a;
                end
                mie_pkg::FN_JALR:
                begin
                    dreg = mie_pkg::LINK_REG;
                    dval = pc_val + 32'd8;
                    taken = 1'b1;
                    target = a;
                end
                mie_pkg::FN_MFHI: dval = hi_val;
                mie_pkg::FN_MFLO: dval = lo_val;
                mie_pkg::FN_MTHI:
                begin
                    dw = 1'b0;
                    r.hilo_write = 1'b1;
                    hi_val = a;
                end
                mie_pkg::FN_MTLO:
                begin
                    dw = 1'b0;
                    r.hilo_write = 1'b1;
                    lo_val = a;
                end
                mie_pkg::FN_MULT, mie_pkg::FN_MULTU:
                begin
                    dw = 1'b0;
                    r.hilo_write = 1'b1;
                    if (fn == mie_pkg::FN_MULT)
                        prod = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
                    else
                        prod = {32'd0, a} * {32'd0, b};
                    lo_val = prod[31:0];
                    hi_val = prod[63:32];
                end
                mie_pkg::FN_DIV, mie_pkg::FN_DIVU:
                begin
                    dw = 1'b0;
                    if (b == 32'd0)
                        r.div_zero = 1'b1;
                    else if (fn == mie_pkg::FN_DIVU)
                    begin
                        r.hilo_write = 1'b1;
                        lo_val = a / b;
                        hi_val = a % b;
                    end
                    else
                    begin
                        logic [31:0] ua;
                        logic [31:0] ub;
                        ua = a[31] ? -a : a;
                        ub = b[31] ? -b : b;
                        r.hilo_write = 1'b1;
                        lo_val = (a[31] != b[31]) ? -(ua / ub) : ua / ub;
                        hi_val = a[31] ? -(ua % ub) : ua % ub;
                    end
                end
                mie_pkg::FN_ADD, mie_pkg::FN_ADDU: dval = a + b;
                mie_pkg::FN_SUB, mie_pkg::FN_SUBU: dval = a - b;
                mie_pkg::FN_AND: dval = a & b;
                mie_pkg::FN_OR: dval = a | b;
                mie_pkg::FN_XOR: dval = a ^ b;
                mie_pkg::FN_NOR: dval = ~(a | b);
                mie_pkg::FN_SLT: dval = {31'd0, $signed(a) < $signed(b)};
                mie_pkg::FN_SLTU: dval = {31'd0, a < b};
                default:
                begin
                    dw = 1'b0;
                    r.illegal_op = 1'b1;
                end
            endcase
        end
        else if (op == mie_pkg::OP_REGIMM)
        begin
            target = btgt;
            case (rt)
                mie_pkg::RI_BLTZ: taken = a[31];
                mie_pkg::RI_BGEZ: taken = !a[31];
                mie_pkg::RI_BLTZAL, mie_pkg::RI_BGEZAL:
                begin
                    taken = (rt == mie_pkg::RI_BLTZAL) ? a[31] : !a[31];
                    dw = 1'b1;
                    dreg = mie_pkg::LINK_REG;
                    dval = pc_val + 32'd8;
                end
                default: r.illegal_op = 1'b1;
            endcase
        end
        else
        begin
            dreg = rt;
            target = btgt;
            case (op)
                mie_pkg::OP_J:
                begin
                    taken = 1'b1;
                    target = jtgt;
                end
                mie_pkg::OP_JAL:
                begin
                    taken = 1'b1;
                    target = jtgt;
                    dw = 1'b1;
                    dreg = mie_pkg::LINK_REG;
                    dval = pc_val + 32'd8;
                end
                mie_pkg::OP_BEQ: taken = (a == b);
                mie_pkg::OP_BNE: taken = (a != b);
                mie_pkg::OP_BLEZ: taken = (a == 32'd0) || a[31];
                mie_pkg::OP_BGTZ: taken = (a != 32'd0) && !a[31];
                mie_pkg::OP_ADDI, mie_pkg::OP_ADDIU:
                begin
                    dw = 1'b1;
                    dval = a + sx16(imm);
                end
                mie_pkg::OP_SLTI:
                begin
                    dw = 1'b1;
                    dval = {31'd0, $signed(a) < $signed(sx16(imm))};
                end
                mie_pkg::OP_SLTIU:
                begin
                    dw = 1'b1;
                    dval = {31'd0, a < sx16(imm)};
                end
                mie_pkg::OP_ANDI:
                begin
                    dw = 1'b1;
                    dval = a & {16'd0, imm};
                end
                mie_pkg::OP_ORI:
                begin
                    dw = 1'b1;
                    dval = a | {16'd0, imm};
                end
                mie_pkg::OP_XORI:
                begin
                    dw = 1'b1;
                    dval = a ^ {16'd0, imm};
                end
                mie_pkg::OP_LUI:
                begin
                    dw = 1'b1;
                    dval = {imm, 16'd0};
                end
                default: r.illegal_op = 1'b1;
            endcase
        end
        if (dw && dreg != 5'd0)
        begin
            gpr[dreg] = dval;
            r.dest_write = 1'b1;
            r.dest_index = dreg;
            r.dest_value = dval;
        end
        r.instr_pc = pc_val;
        r.branch_taken = taken;
        r.next_pc = slot_pending ? slot_target : seq;
        slot_pending = taken;
        if (taken)
            slot_target = target;
        pc_val = r.next_pc;
        result_queue.push_back(r);
    endtask

    function automatic logic [31:0] rand_word();
        logic [5:0] ops [16];
        logic [5:0] fns [26];
        logic [5:0] op;
        logic [31:0] w;
        int k;
        ops = '{mie_pkg::OP_SPECIAL, mie_pkg::OP_SPECIAL, mie_pkg::OP_SPECIAL,
                mie_pkg::OP_REGIMM, mie_pkg::OP_J, mie_pkg::OP_JAL, mie_pkg::OP_BEQ,
                mie_pkg::OP_BNE, mie_pkg::OP_BLEZ, mie_pkg::OP_BGTZ, mie_pkg::OP_ADDI,
                mie_pkg::OP_ADDIU, mie_pkg::OP_SLTI, mie_pkg::OP_SLTIU, mie_pkg::OP_ORI,
                mie_pkg::OP_LUI};
        fns = '{mie_pkg::FN_SLL, mie_pkg::FN_SRL, mie_pkg::FN_SRA, mie_pkg::FN_SLLV,
                mie_pkg::FN_SRLV, mie_pkg::FN_SRAV, mie_pkg::FN_JR, mie_pkg::FN_JALR,
                mie_pkg::FN_MFHI, mie_pkg::FN_MTHI, mie_pkg::FN_MFLO, mie_pkg::FN_MTLO,
                mie_pkg::FN_MULT, mie_pkg::FN_MULTU, mie_pkg::FN_DIV, mie_pkg::FN_DIVU,
                mie_pkg::FN_ADD, mie_pkg::FN_ADDU, mie_pkg::FN_SUB, mie_pkg::FN_SUBU,
                mie_pkg::FN_AND, mie_pkg::FN_OR, mie_pkg::FN_XOR, mie_pkg::FN_NOR,
                mie_pkg::FN_SLT, mie_pkg::FN_SLTU};
        w = $urandom();
        k = $urandom_range(0, 99);
        if (k < 6)
            return w;
        if (k < 10)
            op = $urandom_range(0, 1) ? mie_pkg::OP_ANDI : mie_pkg::OP_XORI;
        else
            op = ops[$urandom_range(0, 15)];
        w[31:26] = op;
        if (op == mie_pkg::OP_SPECIAL)
        begin
            w[5:0] = fns[$urandom_range(0, 25)];
            if ((w[5:0] == mie_pkg::FN_DIV || w[5:0] == mie_pkg::FN_DIVU)
                && $urandom_range(0, 3) == 0)
                w[20:16] = 5'd0;
        end
        else if (op == mie_pkg::OP_REGIMM && $urandom_range(0, 7) != 0)
            w[20:16] = {w[20], 3'b000, w[16]};
        return w;
    endfunction

    task automatic add_instr(logic [31:0] w);
        instr_queue.push_back(w);
    endtask

    task automatic wait_drained();
        while (instr_queue.size() != 0 || result_queue.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    task automatic write_reset_pc(logic [31:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        restart_pc(value);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && in_ch.valid && in_ch.ready)
        begin
            execute_instr(in_ch.instr_word);
            accept_count++;
        end
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            mie_pkg::result_t want;
            result_count++;
            if (result_queue.size() == 0)
                report("unexpected result", out_ch.instr_pc, 32'd0);
            else
            begin
                want = result_queue.pop_front();
                if (out_ch.instr_pc !== want.instr_pc)
                    report("instr_pc", out_ch.instr_pc, want.instr_pc);
                if (out_ch.dest_index !== want.dest_index)
                    report("dest_index", out_ch.dest_index, want.dest_index);
                if (out_ch.dest_value !== want.dest_value)
                    report("dest_value", out_ch.dest_value, want.dest_value);
                if (out_ch.dest_write !== want.dest_write)
                    report("dest_write", out_ch.dest_write, want.dest_write);
                if (out_ch.hilo_write !== want.hilo_write)
                    report("hilo_write", out_ch.hilo_write, want.hilo_write);
                if (out_ch.branch_taken !== want.branch_taken)
                    report("branch_taken", out_ch.branch_taken, want.branch_taken);
                if (out_ch.next_pc !== want.next_pc)
                    report("next_pc", out_ch.next_pc, want.next_pc);
                if (out_ch.illegal_op !== want.illegal_op)
                    report("illegal_op", out_ch.illegal_op, want.illegal_op);
                if (out_ch.div_zero !== want.div_zero)
                    report("div_zero", out_ch.div_zero, want.div_zero);
            end
        end
    end

    // The item on the channel is retired once the monitor has seen it accepted.
    always @(negedge clk)
    begin
        logic in_done;
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            out_ch.ready <= 1'b0;
        end
        else
        begin
            in_done = (accept_count != pop_count);
            if (in_done)
            begin
                void'(instr_queue.pop_front());
                pop_count++;
                send_gap = pick_gap();
            end
            if (!in_ch.valid || in_done)
            begin
                if (send_gap > 0 || hold_sender || instr_queue.size() == 0)
                begin
                    in_ch.valid <= 1'b0;
                    if (send_gap > 0)
                        send_gap--;
                end
                else
                begin
                    in_ch.valid <= 1'b1;
                    in_ch.instr_word <= instr_queue[0];
                end
            end
            if (recv_gap > 0)
            begin
                out_ch.ready <= 1'b0;
                recv_gap--;
            end
            else
            begin
                out_ch.ready <= 1'b1;
                if (cycle_count % 1000 < 300)
                    recv_gap = 0;
                else
                    recv_gap = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > 400000)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        error_count = 0;
        result_count = 0;
        accept_count = 0;
        pop_count = 0;
        cycle_count = 0;
        hold_sender = 1'b0;
        send_gap = 0;
        recv_gap = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.instr_word = '0;
        out_ch.ready = 1'b0;
        for (int i = 0; i < 32; i++)
            gpr[i] = '0;
        hi_val = '0;
        lo_val = '0;
        slot_target = '0;
        restart_pc(mie_pkg::PC_RESET);
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Operands: r1 = 0x80000000, r2 = -1, r3 = 0x7fffffff and then 0x80000000, r4 = 7, r5 = -7.
        add_instr({mie_pkg::OP_LUI, 5'd0, 5'd1, 16'h8000});
        add_instr({mie_pkg::OP_ADDIU, 5'd0, 5'd2, 16'hFFFF});
        add_instr({mie_pkg::OP_ADDI, 5'd2, 5'd3, 16'h0000}
                  | {mie_pkg::OP_LUI, 5'd0, 5'd0, 16'd0});
        add_instr({mie_pkg::OP_SPECIAL, 5'd1, 5'd2, 5'd3, 5'd0, mie_pkg::FN_ADD});
        add_instr({mie_pkg::OP_ADDI, 5'd3, 5'd3, 16'h0001});
        add_instr({mie_pkg::OP_ORI, 5'd0, 5'd4, 16'h0007});
        add_instr({mie_pkg::OP_SPECIAL, 5'd0, 5'd4, 5'd5, 5'd0, mie_pkg::FN_SUB});
        add_instr({mie_pkg::OP_SPECIAL, 5'd1, 5'd2, 5'd0, 5'd0, mie_pkg::FN_DIV});
        add_instr({mie_pkg::OP_SPECIAL, 5'd0, 5'd0, 5'd6, 5'd0, mie_pkg::FN_MFLO});
        add_instr({mie_pkg::OP_SPECIAL, 5'd5, 5'd4, 5'd0, 5'd0, mie_pkg::FN_DIV});
        add_instr({mie_pkg::OP_SPECIAL, 5'd0, 5'd0, 5'd7, 5'd0, mie_pkg::FN_MFHI});
        add_instr({mie_pkg::OP_SPECIAL, 5'd4, 5'd0, 5'd0, 5'd0, mie_pkg::FN_DIVU});
        add_instr({mie_pkg::OP_SPECIAL, 5'd2, 5'd2, 5'd0, 5'd0, mie_pkg::FN_MULT});
        add_instr({mie_pkg::OP_SPECIAL, 5'd2, 5'd2, 5'd0, 5'd0, mie_pkg::FN_MULTU});
        add_instr({mie_pkg::OP_SPECIAL, 5'd0, 5'd1, 5'd8, 5'd31, mie_pkg::FN_SRA});
        add_instr({mie_pkg::OP_SPECIAL, 5'd4, 5'd4, 5'd0, 5'd0, mie_pkg::FN_ADDU});
        add_instr({mie_pkg::OP_JAL, 26'h3FF_FFFF});
        add_instr({mie_pkg::OP_BEQ, 5'd0, 5'd0, 16'h8000});
        add_instr({mie_pkg::OP_SPECIAL, 5'd1, 5'd0, 5'd9, 5'd0, mie_pkg::FN_JALR});
        add_instr({mie_pkg::OP_REGIMM, 5'd1, mie_pkg::RI_BLTZAL, 16'h7FFF});
        add_instr({mie_pkg::OP_REGIMM, 5'd1, 5'd2, 16'h0000});
        add_instr(32'h0000_000C);
        add_instr(32'h8C00_0000);
        add_instr(32'hFFFF_FFFF);
        wait_drained();

        write_reset_pc(32'h0000_0000);
        for (int i = 0; i < 300; i++)
            add_instr(rand_word());
        while (instr_queue.size() > 150)
            @(posedge clk);
        hold_sender = 1'b1;
        while (result_queue.size() != 0)
            @(posedge clk);
        hold_sender = 1'b0;
        wait_drained();

        write_reset_pc(32'hFFFF_FFFC);
        for (int i = 0; i < 300; i++)
            add_instr(rand_word());
        wait_drained();

        write_reset_pc($urandom());
        for (int i = 0; i < 300; i++)
            add_instr(rand_word());
        wait_drained();

        if (result_queue.size() != 0)
            report("results left over", result_queue.size(), 32'd0);
        $display("Ran %0d instructions through all groups, including divide corner cases,",
                 accept_count);
        $display("delay-slot branches, illegal encodings and four reset_pc settings.");
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* filelist.f */
sv/mie_pkg.sv
sv/mie_in_if.sv
sv/mie_out_if.sv
sv/mie_ctrl.sv
sv/mie_dp.sv
sv/mips32_integer_execute.sv
sim/tb.sv
